/* rtl/dpd_pkg.sv */
// ----------------------------------------------------------------------------
// dpd_pkg: shared types and constants for the dosage probability decoder
// Field widths, flag positions, fixed-point unit and the packed forms of one
// subject's input transaction and decoded result.
// ----------------------------------------------------------------------------
package dpd_pkg;

    localparam int WORD_W  = 16;
    localparam int PROB_W  = 18;
    localparam int USED_W  = 2;
    localparam int FLAG_IX = 15;

    localparam int S_TDATA_W = 4 * WORD_W;
    localparam int M_TDATA_W = WORD_W + 3 * PROB_W + USED_W;

    // 1.0 in units of 1/20000
    localparam logic signed [PROB_W-1:0] UNIT_ONE = 18'sd20000;
    localparam logic signed [PROB_W-1:0] UNIT_TWO = 18'sd40000;

    // Extra words consumed per subject
    localparam logic [USED_W-1:0] USED_NONE  = 2'd0;
    localparam logic [USED_W-1:0] USED_ONE   = 2'd1;
    localparam logic [USED_W-1:0] USED_THREE = 2'd3;

    typedef logic [WORD_W-1:0]        word_t;
    typedef logic signed [PROB_W-1:0] prob_t;

    typedef struct packed {
        word_t extra_third;
        word_t extra_second;
        word_t extra_first;
        word_t dosage_word;
    } subj_in_t;

    typedef struct packed {
        logic [USED_W-1:0] words_used;
        prob_t             prob_two;
        prob_t             prob_one;
        prob_t             prob_zero;
        word_t             dosage_value;
    } subj_res_t;

endpackage

/* rtl/dpd_decode.sv */
// ----------------------------------------------------------------------------
// dpd_decode: combinational decode of one subject's dosage entry
// Selects the dosage-only, one-word or three-word form from the flag bits and
// forms dosage and three genotype probabilities in units of 1/20000.
// ----------------------------------------------------------------------------
module dpd_decode (
    input  dpd_pkg::subj_in_t  subj_in,
    output dpd_pkg::subj_res_t subj_res
);
    import dpd_pkg::*;

    prob_t dose2;     // 2 * low 15 bits of dosage word
    prob_t dose1;     // low 15 bits of dosage word
    prob_t ext1_low;  // low 15 bits of first extra word
    prob_t ext1_2x;
    prob_t p2_one;

    assign dose1    = {3'b000, subj_in.dosage_word[FLAG_IX-1:0]};
    assign dose2    = {2'b00, subj_in.dosage_word[FLAG_IX-1:0], 1'b0};
    assign ext1_low = {3'b000, subj_in.extra_first[FLAG_IX-1:0]};
    assign ext1_2x  = {2'b00, subj_in.extra_first[FLAG_IX-1:0], 1'b0};
    // (D - P1) / 2 with both even is just the halved difference
    assign p2_one   = dose1 - ext1_low;

    always_comb begin
        subj_res.dosage_value = dose2[WORD_W-1:0];
        if (subj_in.dosage_word[FLAG_IX]) begin
            if (subj_in.extra_first[FLAG_IX]) begin
                subj_res.prob_one   = ext1_2x;
                subj_res.prob_zero  = {subj_in.extra_second[WORD_W-1],
                                       subj_in.extra_second, 1'b0};
                subj_res.prob_two   = {subj_in.extra_third[WORD_W-1],
                                       subj_in.extra_third, 1'b0};
                subj_res.words_used = USED_THREE;
            end else begin
                subj_res.prob_one   = ext1_2x;
                subj_res.prob_two   = p2_one;
                subj_res.prob_zero  = UNIT_ONE - ext1_2x - p2_one;
                subj_res.words_used = USED_ONE;
            end
        end else begin
            if (dose2 > UNIT_ONE) begin
                subj_res.prob_zero = '0;
                subj_res.prob_two  = dose2 - UNIT_ONE;
                subj_res.prob_one  = UNIT_TWO - dose2;
            end else begin
                subj_res.prob_zero = UNIT_ONE - dose2;
                subj_res.prob_one  = dose2;
                subj_res.prob_two  = '0;
            end
            subj_res.words_used = USED_NONE;
        end
    end

endmodule

/* rtl/dosage_probability_decoder.sv */
// ----------------------------------------------------------------------------
// dosage_probability_decoder: per-subject genotype dosage decoder
// Streams one subject entry in and one decoded dosage/probability result out.
// ----------------------------------------------------------------------------
// One transaction on the s_ side carries a subject's dosage word plus a window
// of the next three unconsumed extra words; one transaction on the m_ side
// returns the dosage and the three genotype probabilities, all exact integers
// in units of 1/20000, and words_used (0, 1 or 3) so the feeder can advance
// its window. The block holds no state between subjects. It is a two-stage
// pipeline: an input register, the decode logic (a few 18-bit adds and a
// compare), and a result register. An accepted subject is captured in the
// input register and its decoded result then moves into the result register
// that drives m_tvalid. A new subject is taken every cycle while the m_ side
// keeps up; throughput is set by the single decode stage, one subject per clock.
// Backpressure on m_tready stalls both stages; s_tready stays high while the
// input stage is empty or moving forward.
// ----------------------------------------------------------------------------
module dosage_probability_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: dosage_word[15:0], extra_first[31:16],
    //          extra_second[47:32], extra_third[63:48]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dpd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,   // last_subject
    // m_tdata: dosage_value[15:0], prob_zero[33:16], prob_one[51:34],
    //          prob_two[69:52], words_used[71:70]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dpd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast    // last
);
    import dpd_pkg::*;

    // input stage
    logic      in_valid_reg, in_valid_next;
    subj_in_t  in_item_reg;
    logic      in_last_reg;

    // result stage
    logic      out_valid_reg, out_valid_next;
    subj_res_t out_res_reg;
    logic      out_last_reg;

    logic      out_ready;   // result stage can take a new entry
    logic      in_ready;    // input stage can take a new transaction
    subj_res_t dec_res;

    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;

    assign in_valid_next  = in_ready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_ready ? in_valid_reg : out_valid_reg;

    dpd_decode u_decode (
        .subj_in  (in_item_reg),
        .subj_res (dec_res)
    );

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && in_ready) begin
            in_item_reg <= subj_in_t'(s_tdata);
            in_last_reg <= s_tlast;
        end
        if (in_valid_reg && out_ready) begin
            out_res_reg  <= dec_res;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_res_reg);
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/dpd_checker.sv */
// ----------------------------------------------------------------------------
// dpd_checker: port-level checks for the dosage probability decoder
// Watches the result channel for reset, stall and decode consistency.
// ----------------------------------------------------------------------------
module dpd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dpd_pkg::M_TDATA_W-1:0] m_tdata
);
    import dpd_pkg::*;

    logic [USED_W-1:0]       used;
    logic signed [PROB_W+1:0] prob_sum;

    assign used     = m_tdata[M_TDATA_W-1 -: USED_W];
    assign prob_sum = PROB_W'(0) + $signed({{2{m_tdata[33]}}, m_tdata[33:16]})
                    + $signed({{2{m_tdata[51]}}, m_tdata[51:34]})
                    + $signed({{2{m_tdata[69]}}, m_tdata[69:52]});

    // nothing comes out of the pipe right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled result is held
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // only 0, 1 or 3 extra words are ever consumed
    a_used_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> used == USED_NONE || used == USED_ONE || used == USED_THREE)
        else $error("illegal words_used");

    // derived forms always sum to one
    a_sum_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && used != USED_THREE |-> prob_sum == 20'sd20000)
        else $error("derived probabilities do not sum to one");

    // dosage-only form leaves p0 or p2 at zero
    a_dose_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && used == USED_NONE |->
            m_tdata[33:16] == '0 || m_tdata[69:52] == '0)
        else $error("dosage-only form with both p0 and p2 nonzero");

endmodule

bind dosage_probability_decoder dpd_checker u_dpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for dosage_probability_decoder
// Drives subject transactions on the s_ stream and checks every m_ result,
// field by field and in order, against a hand-derived or behavioral decode of
// the same subject. A short table of directed subjects comes first, then random
// ones. The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;

    import dpd_pkg::*;

    localparam int RANDOM_SUBJECTS = 1400;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_GUARD     = 20000;

    // Expected result of one subject: the m_tdata fields plus m_tlast.
    typedef struct packed {
        logic      last;
        subj_res_t res;
    } decoded_t;

    // One directed subject. Rows marked typed carry a hand-derived result;
    // the rest are checked against decode_subject.
    typedef struct {
        subj_in_t stim;
        logic     lst;
        logic     typed;
        decoded_t fixed;
    } table_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // dosage_word, extra_first, extra_second, extra_third
    logic                 s_tlast;   // last_subject
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // dosage_value, prob_zero, prob_one, prob_two, words_used
    logic                 m_tlast;   // last

    decoded_t   pending_decodes[$];  // results owed by the block, oldest first
    table_row_t stim_table[$];
    int         fail_count;
    int         burst_left;
    logic [7:0] rx_pattern;
    int         rx_left;

    dosage_probability_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Behavioral decode of one subject. All values are plain ints in
    // units of 1/20000 and get cut to the port widths at the end.
    // ------------------------------------------------------------------
    function automatic decoded_t decode_subject(subj_in_t s, logic lst);
        decoded_t   r;
        int         d;
        int         p0;
        int         p1;
        int         p2;
        int         one;
        logic [1:0] used;
        one = int'(UNIT_ONE);
        if (s.dosage_word[FLAG_IX]) begin
            d = 2 * int'(s.dosage_word[FLAG_IX-1:0]);
            if (s.extra_first[FLAG_IX]) begin
                // three-word form: all probabilities read directly
                p1   = 2 * int'(s.extra_first[FLAG_IX-1:0]);
                p0   = 2 * int'($signed(s.extra_second));
                p2   = 2 * int'($signed(s.extra_third));
                used = USED_THREE;
            end else begin
                // one-word form: p1 read, p2 and p0 derived (halving is exact)
                p1   = 2 * int'(s.extra_first);
                p2   = (d - p1) / 2;
                p0   = one - p1 - p2;
                used = USED_ONE;
            end
        end else begin
            // probabilities follow from the dosage alone
            d = 2 * int'(s.dosage_word);
            if (d > one) begin
                p0 = 0;
                p2 = d - one;
                p1 = one - p2;
            end else begin
                p1 = d;
                p0 = one - d;
                p2 = 0;
            end
            used = USED_NONE;
        end
        r.res.dosage_value = word_t'(d);
        r.res.prob_zero    = prob_t'(p0);
        r.res.prob_one     = prob_t'(p1);
        r.res.prob_two     = prob_t'(p2);
        r.res.words_used   = used;
        r.last             = lst;
        return r;
    endfunction

    function automatic void row_typed(word_t dw, word_t e1, word_t e2, word_t e3, logic lst,
                                      int dv, int p0, int p1, int p2, logic [1:0] used);
        table_row_t row;
        row.stim                   = '{extra_third: e3, extra_second: e2,
                                       extra_first: e1, dosage_word: dw};
        row.lst                    = lst;
        row.typed                  = 1'b1;
        row.fixed.last             = lst;
        row.fixed.res.dosage_value = word_t'(dv);
        row.fixed.res.prob_zero    = prob_t'(p0);
        row.fixed.res.prob_one     = prob_t'(p1);
        row.fixed.res.prob_two     = prob_t'(p2);
        row.fixed.res.words_used   = used;
        stim_table.push_back(row);
    endfunction

    function automatic void row_plain(word_t dw, word_t e1, word_t e2, word_t e3, logic lst);
        table_row_t row;
        row.stim  = '{extra_third: e3, extra_second: e2, extra_first: e1, dosage_word: dw};
        row.lst   = lst;
        row.typed = 1'b0;
        row.fixed = '0;
        stim_table.push_back(row);
    endfunction

    // Random subject, spread evenly over the three decode paths.
    function automatic subj_in_t random_subject();
        subj_in_t s;
        s.extra_first  = word_t'($urandom);
        s.extra_second = word_t'($urandom);
        s.extra_third  = word_t'($urandom);
        case ($urandom_range(0, 2))
            0: begin
                s.dosage_word = {1'b0, 15'($urandom)};
                // crowd the 1.0 boundary now and then
                if ($urandom_range(0, 3) == 0)
                    s.dosage_word = word_t'($urandom_range(9990, 10010));
            end
            1: begin
                s.dosage_word = {1'b1, 15'($urandom)};
                s.extra_first = {1'b0, 15'($urandom)};
            end
            default: begin
                s.dosage_word = {1'b1, 15'($urandom)};
                s.extra_first = {1'b1, 15'($urandom)};
            end
        endcase
        return s;
    endfunction

    function automatic void note_failure(string what, int expv, int actv);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, expv, actv);
        fail_count++;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Inputs move on the falling edge only; a transaction is
    // taken at the rising edge where s_tvalid and s_tready are both high.
    // ------------------------------------------------------------------
    task automatic hold_off(int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};   // junk while idle
            s_tlast  <= 1'($urandom);
        end
    endtask

    task automatic feed(subj_in_t s, logic lst, decoded_t exp_res);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 8));
            // occasional long stretch with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        pending_decodes.push_back(exp_res);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_decodes.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver stall pattern: an 8-bit mask rotated each cycle and reloaded
    // when rx_left runs out. Some reloads are all ones, giving stall-free runs.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_left    = 64;
            rx_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom_range(1, 255));
        end
        rx_left--;
        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
        m_tready <= rx_pattern[0];
    end

    // ------------------------------------------------------------------
    // Result check: each m_ transaction against the oldest owed result.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        decoded_t  want;
        subj_res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_decodes.size() == 0) begin
                note_failure("unexpected result transaction", 0, 1);
            end else begin
                want = pending_decodes.pop_front();
                if (got.dosage_value !== want.res.dosage_value)
                    note_failure("dosage_value", int'(want.res.dosage_value),
                                 int'(got.dosage_value));
                if (got.prob_zero !== want.res.prob_zero)
                    note_failure("prob_zero", int'(want.res.prob_zero), int'(got.prob_zero));
                if (got.prob_one !== want.res.prob_one)
                    note_failure("prob_one", int'(want.res.prob_one), int'(got.prob_one));
                if (got.prob_two !== want.res.prob_two)
                    note_failure("prob_two", int'(want.res.prob_two), int'(got.prob_two));
                if (got.words_used !== want.res.words_used)
                    note_failure("words_used", int'(want.res.words_used),
                                 int'(got.words_used));
                if (m_tlast !== want.last)
                    note_failure("last", int'(want.last), int'(m_tlast));
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #8000000;
        $display("dosage_probability_decoder verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        subj_in_t s;
        logic     lst;

        aclk       = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        fail_count = 0;
        burst_left = 0;
        rx_pattern = 8'hff;
        rx_left    = 0;

        // Directed table. Typed rows: dosage-only decode at zero, both sides
        // of 1.0 and full scale; one-word form at its extremes; three-word
        // form with the most negative p0 and largest p1/p2, and with all zeros.
        row_typed(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                  0, 20000, 0, 0, USED_NONE);
        row_typed(16'd9999, 16'hffff, 16'hffff, 16'hffff, 1'b0,
                  19998, 2, 19998, 0, USED_NONE);
        row_typed(16'd10000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                  20000, 0, 20000, 0, USED_NONE);
        row_typed(16'd10001, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                  20002, 0, 19998, 2, USED_NONE);
        row_typed(16'h7fff, 16'hffff, 16'h0000, 16'hffff, 1'b1,
                  65534, 0, -25534, 45534, USED_NONE);
        row_typed(16'hffff, 16'h0000, 16'hffff, 16'hffff, 1'b0,
                  65534, -12767, 0, 32767, USED_ONE);
        row_typed(16'h8000, 16'h7fff, 16'h0000, 16'h0000, 1'b0,
                  0, -12767, 65534, -32767, USED_ONE);
        row_typed(16'h8000, 16'hffff, 16'h8000, 16'h7fff, 1'b0,
                  0, -65536, 65534, 65534, USED_THREE);
        row_typed(16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b1,
                  0, 0, 0, 0, USED_THREE);
        // Predicted rows: mid-range values and alternating bit patterns
        row_plain(16'h1234, 16'hffff, 16'hffff, 16'hffff, 1'b1);
        row_plain(16'h5555, 16'haaaa, 16'haaaa, 16'haaaa, 1'b0);
        row_plain(16'h8000 | 16'd5000, 16'd5000, 16'h1111, 16'h2222, 1'b0);
        row_plain(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b0);
        row_plain(16'hd555, 16'haaaa, 16'h5555, 16'h5555, 1'b1);
        row_plain(16'h9234, 16'hffff, 16'hffff, 16'hffff, 1'b0);
        row_plain(16'hffff, 16'h8000 | 16'd2500, 16'd5000, 16'd12500, 1'b1);
        row_plain(16'hc000, 16'h7ffe, 16'h0001, 16'h8001, 1'b0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[i])
            feed(stim_table[i].stim, stim_table[i].lst,
                 stim_table[i].typed ? stim_table[i].fixed
                                     : decode_subject(stim_table[i].stim, stim_table[i].lst));

        for (int n = 0; n < RANDOM_SUBJECTS; n++) begin
            // halfway through, let the pipeline run completely dry
            if (n == RANDOM_SUBJECTS / 2) begin
                hold_off(1);
                wait_drained();
                burst_left = 0;
            end
            s   = random_subject();
            lst = ($urandom_range(0, 7) == 0);
            feed(s, lst, decode_subject(s, lst));
        end

        hold_off(1);
        wait_drained();
        repeat (8) @(posedge aclk);
        if (pending_decodes.size() != 0)
            note_failure("results never delivered", 0, pending_decodes.size());

        if (fail_count == 0) begin
            $display("dosage_probability_decoder verification clean");
        end else begin
            $display("dosage_probability_decoder verification failed");
        end
        $finish;
    end

endmodule

/* dosage_probability_decoder.f */
rtl/dpd_pkg.sv
rtl/dpd_decode.sv
rtl/dosage_probability_decoder.sv
rtl/dpd_checker.sv
tb/tb.sv
